// File: rtl/bracket_nesting_checker_defines.svh
// Assertion macros used by the bracket nesting checker RTL.
`ifndef BRACKET_NESTING_CHECKER_DEFINES_SVH
`define BRACKET_NESTING_CHECKER_DEFINES_SVH

`ifndef SYNTHESIS

// Check that cons holds in the same cycle whenever ante holds.
`define BNC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bracket_nesting_checker: same-cycle check failed");

// Check that cons holds in the cycle after ante holds.
`define BNC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bracket_nesting_checker: next-cycle check failed");

`else

`define BNC_ASSERT_NOW(lbl, ante, cons)
`define BNC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: rtl/bnc_pkg.sv
// Types, constants and the character decoder of the bracket nesting checker.
`default_nettype none

package bnc_pkg;

  localparam int StackDepth = 256;
  localparam int CountW     = $clog2(StackDepth + 1);
  localparam int AddrW      = (StackDepth > 1) ? $clog2(StackDepth) : 1;

  localparam logic [7:0] ChAngleOpen   = 8'h3C;  // <
  localparam logic [7:0] ChParenOpen   = 8'h28;  // (
  localparam logic [7:0] ChSquareOpen  = 8'h5B;  // [
  localparam logic [7:0] ChBraceOpen   = 8'h7B;  // {
  localparam logic [7:0] ChAngleClose  = 8'h3E;  // >
  localparam logic [7:0] ChParenClose  = 8'h29;  // )
  localparam logic [7:0] ChSquareClose = 8'h5D;  // ]
  localparam logic [7:0] ChBraceClose  = 8'h7D;  // }

  // Bracket kinds, ordered from innermost to outermost.
  typedef enum logic [1:0] {
    KIND_ANGLE  = 2'd0,
    KIND_PAREN  = 2'd1,
    KIND_SQUARE = 2'd2,
    KIND_BRACE  = 2'd3
  } kind_e;

  typedef struct packed {
    logic  is_open;
    logic  is_close;
    kind_e kind;
  } sym_class_t;

  function automatic sym_class_t classify(input logic [7:0] sym);
    sym_class_t c;
    c = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_ANGLE};
    unique case (sym)
      ChAngleOpen:   c = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_ANGLE};
      ChParenOpen:   c = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_PAREN};
      ChSquareOpen:  c = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_SQUARE};
      ChBraceOpen:   c = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_BRACE};
      ChAngleClose:  c = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_ANGLE};
      ChParenClose:  c = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_PAREN};
      ChSquareClose: c = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_SQUARE};
      ChBraceClose:  c = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_BRACE};
      default:       c = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_ANGLE};
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/bnc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bnc_ram #(
  parameter int Width = 2,
  parameter int Depth = 256,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: rtl/bracket_nesting_checker.sv
// Top level of the bracket nesting checker: stack control, RAM and result register.
//
// Usage:
//   Input channel carries one character word per handshake (symbol_i) plus
//   last_symbol_i, which marks the final character of a string. A word is
//   taken on a rising edge with in_valid_i high and in_stall_o low.
//   Output channel carries one word per string (balanced_o), presented in the
//   cycle after the last character is taken and held until out_stall_i is low.
//   Throughput: one character per cycle while in_stall_o is low. The top of the stack
//   lives in a register and the entry below it is read ahead from the stack
//   RAM on its single registered read port, so a push or pop never waits.
//   Latency: the result appears on the cycle after the last character.
//   Stall: while a result waits and the receiver stalls, in_stall_o is high
//   and no character is taken; a stall-free receiver never slows the input.
//   Reset: clears the stack count, the failure flag and the output valid.
//   The stack RAM is not cleared; only entries below the count are relied on.
//   End of string: the count and failure flag clear on the last character.
`default_nettype none
`include "bracket_nesting_checker_defines.svh"

module bracket_nesting_checker (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] symbol_i,
  input  wire logic       last_symbol_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            balanced_o
);

  localparam int CountW = bnc_pkg::CountW;
  localparam int AddrW  = bnc_pkg::AddrW;

  // Stack state: count, top-of-stack kind, sticky failure flag.
  logic [CountW-1:0] count_q, count_d;
  bnc_pkg::kind_e    top_q, top_d;
  logic              failed_q, failed_d;

  // Forwarding of the word written in the previous cycle, which is also the
  // address read in that cycle.
  logic              byp_q;
  bnc_pkg::kind_e    byp_data_q;

  logic              out_valid_q, out_valid_d;
  logic              balanced_q, balanced_d;

  logic              in_acc;
  bnc_pkg::sym_class_t cls;
  logic              empty, full;
  logic              fail_now, push, pop;
  logic [CountW-1:0] count_n;
  bnc_pkg::kind_e    below;
  logic [1:0]        ram_rdata;
  logic              ram_we;
  logic [CountW-1:0] waddr_full, raddr_full;

  // Hold input while a result waits on a stalled receiver.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign cls   = bnc_pkg::classify(symbol_i);
  assign empty = (count_q == '0);
  assign full  = (count_q == CountW'(bnc_pkg::StackDepth));
  assign below = byp_q ? byp_data_q : bnc_pkg::kind_e'(ram_rdata);

  always_comb begin
    fail_now = 1'b0;
    if (!failed_q) begin
      if (cls.is_open) begin
        // Opener inside a more inner kind, or stack overflow.
        fail_now = (!empty && (top_q < cls.kind)) || full;
      end else if (cls.is_close) begin
        // Closer on an empty stack or of the wrong kind.
        fail_now = empty || (top_q != cls.kind);
      end
    end
    push = !failed_q && cls.is_open && !fail_now;
    pop  = !failed_q && cls.is_close && !fail_now;

    if (push) begin
      count_n = count_q + CountW'(1);
    end else if (pop) begin
      count_n = count_q - CountW'(1);
    end else begin
      count_n = count_q;
    end

    count_d     = count_q;
    top_d       = top_q;
    failed_d    = failed_q;
    balanced_d  = balanced_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (in_acc) begin
      if (push) begin
        top_d = cls.kind;
      end else if (pop) begin
        top_d = below;
      end
      if (last_symbol_i) begin
        // Emit the verdict and start the next string clean.
        balanced_d  = !(failed_q || fail_now) && (count_n == '0);
        out_valid_d = 1'b1;
        count_d     = '0;
        failed_d    = 1'b0;
      end else begin
        count_d  = count_n;
        failed_d = failed_q || fail_now;
      end
    end
  end

  // A push spills the old top to the RAM slot just below the new top.
  assign ram_we     = in_acc && push && !empty;
  assign waddr_full = count_q - CountW'(1);
  // Read ahead the entry below the next top.
  assign raddr_full = count_d - CountW'(2);

  bnc_ram #(
    .Width (2),
    .Depth (bnc_pkg::StackDepth)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr_full[AddrW-1:0]),
    .wdata_i (top_q),
    .raddr_i (raddr_full[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      failed_q    <= 1'b0;
      byp_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      failed_q    <= failed_d;
      byp_q       <= ram_we;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q      <= top_d;
    byp_data_q <= top_q;
    balanced_q <= balanced_d;
  end

  assign out_valid_o = out_valid_q;
  assign balanced_o  = balanced_q;

  `BNC_ASSERT_NEXT(a_last_clears, in_acc && last_symbol_i, count_q == '0 && !failed_q)
  `BNC_ASSERT_NEXT(a_fail_sticky, in_acc && !last_symbol_i && failed_q, failed_q)
  `BNC_ASSERT_NOW(a_result_source, $rose(out_valid_q), $past(in_acc && last_symbol_i))
  `BNC_ASSERT_NEXT(a_push_top, in_acc && push && !last_symbol_i, top_q == $past(cls.kind))
  `BNC_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CountW'(bnc_pkg::StackDepth))

endmodule

`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench of the bracket nesting checker: directed strings, full-stack strings, then random strings.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bnc_pkg::*;

  localparam int Depth       = StackDepth;
  localparam int RandomWords = 500;

  // One row of the directed table; typed rows carry their verdict, the rest are predicted.
  typedef struct packed {
    logic [7:0] sym;
    logic       last;
    logic       typed;
    logic       verdict;
  } stim_row_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HALF,
    STALL_HEAVY
  } stall_mode_e;

  localparam int DirRows = 24;
  localparam stim_row_t DirTable [DirRows] = '{
    '{8'h61,         1'b1, 1'b1, 1'b1},  // lone plain character: nothing open, balanced
    '{ChBraceClose,  1'b1, 1'b1, 1'b0},  // closer with nothing open
    '{ChBraceOpen,   1'b0, 1'b0, 1'b0},  // every kind, outermost to innermost
    '{ChSquareOpen,  1'b0, 1'b0, 1'b0},
    '{ChParenOpen,   1'b0, 1'b0, 1'b0},
    '{ChAngleOpen,   1'b0, 1'b0, 1'b0},
    '{ChAngleClose,  1'b0, 1'b0, 1'b0},
    '{ChParenClose,  1'b0, 1'b0, 1'b0},
    '{ChSquareClose, 1'b0, 1'b0, 1'b0},
    '{ChBraceClose,  1'b1, 1'b1, 1'b1},
    '{ChAngleOpen,   1'b0, 1'b0, 1'b0},  // outer kind opened inside an inner one
    '{ChParenOpen,   1'b1, 1'b1, 1'b0},
    '{ChParenOpen,   1'b0, 1'b0, 1'b0},  // wrong closer, then the right one is skipped
    '{ChSquareClose, 1'b0, 1'b0, 1'b0},
    '{ChParenClose,  1'b1, 1'b1, 1'b0},
    '{ChSquareOpen,  1'b0, 1'b0, 1'b0},  // extreme codes in between are ignored
    '{8'h00,         1'b0, 1'b0, 1'b0},
    '{8'hFF,         1'b0, 1'b0, 1'b0},
    '{ChSquareClose, 1'b1, 1'b0, 1'b0},
    '{ChBraceOpen,   1'b1, 1'b1, 1'b0},  // left open at the end
    '{ChParenOpen,   1'b0, 1'b0, 1'b0},  // same kind nested in itself
    '{ChParenOpen,   1'b0, 1'b0, 1'b0},
    '{ChParenClose,  1'b0, 1'b0, 1'b0},
    '{ChParenClose,  1'b1, 1'b0, 1'b0}
  };

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       in_valid_i    = 1'b0;
  logic       in_stall_o;
  logic [7:0] symbol_i      = 8'h00;
  logic       last_symbol_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i   = 1'b0;
  logic       balanced_o;

  // Expected stack of open kinds and the sticky failure of the current string.
  kind_e       kind_stack [Depth];
  int unsigned stack_fill    = 0;
  bit          string_failed = 1'b0;
  int unsigned deepest_fill  = 0;

  bit          verdict_q [$];
  int          error_count   = 0;
  int          verdicts_seen = 0;
  int          balanced_seen = 0;
  int          words_sent    = 0;
  int          burst_left    = 0;

  stall_mode_e stall_mode = STALL_NONE;
  int          stall_left = 0;

  bracket_nesting_checker dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .symbol_i     (symbol_i),
    .last_symbol_i(last_symbol_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .balanced_o   (balanced_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Return 1 for any bracket character, with its kind and direction.
  function automatic bit bracket_of(input logic [7:0] ch, output kind_e kind, output bit opener);
    kind   = KIND_ANGLE;
    opener = 1'b0;
    case (ch)
      ChAngleOpen: begin
        kind   = KIND_ANGLE;
        opener = 1'b1;
      end
      ChParenOpen: begin
        kind   = KIND_PAREN;
        opener = 1'b1;
      end
      ChSquareOpen: begin
        kind   = KIND_SQUARE;
        opener = 1'b1;
      end
      ChBraceOpen: begin
        kind   = KIND_BRACE;
        opener = 1'b1;
      end
      ChAngleClose:  kind = KIND_ANGLE;
      ChParenClose:  kind = KIND_PAREN;
      ChSquareClose: kind = KIND_SQUARE;
      ChBraceClose:  kind = KIND_BRACE;
      default:       return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic logic [7:0] opener_char(input kind_e kind);
    case (kind)
      KIND_ANGLE:  return ChAngleOpen;
      KIND_PAREN:  return ChParenOpen;
      KIND_SQUARE: return ChSquareOpen;
      default:     return ChBraceOpen;
    endcase
  endfunction

  function automatic logic [7:0] closer_char(input kind_e kind);
    case (kind)
      KIND_ANGLE:  return ChAngleClose;
      KIND_PAREN:  return ChParenClose;
      KIND_SQUARE: return ChSquareClose;
      default:     return ChBraceClose;
    endcase
  endfunction

  // Advance the expected stack by one accepted word; on the last word return 1 with the verdict
  // and clear the stack and the failure for the next string.
  function automatic bit step_nesting(input logic [7:0] ch, input bit last, output bit verdict);
    kind_e kind;
    bit    opener;
    verdict = 1'b0;
    if (!string_failed && bracket_of(ch, kind, opener)) begin
      if (opener) begin
        // Outer kind on top of an inner one, or no room left: fail, push nothing.
        if ((stack_fill > 0 && kind_stack[stack_fill-1] < kind) || stack_fill >= Depth) begin
          string_failed = 1'b1;
        end else begin
          kind_stack[stack_fill] = kind;
          stack_fill++;
        end
      end else if (stack_fill == 0 || kind_stack[stack_fill-1] != kind) begin
        string_failed = 1'b1;
      end else begin
        stack_fill--;
      end
      if (stack_fill > deepest_fill) deepest_fill = stack_fill;
    end
    if (!last) return 1'b0;
    verdict       = !string_failed && stack_fill == 0;
    stack_fill    = 0;
    string_failed = 1'b0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    $display("testbench: MISMATCH at %0t ns: %s", $time, what);
    error_count++;
  endtask

  // Present one word, holding it until taken; insert a random gap at the start of each burst.
  task automatic send_word(input logic [7:0] ch, input bit last, input bit typed = 1'b0,
                           input bit typed_verdict = 1'b0);
    int unsigned gap;
    bit          verdict;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 24) : $urandom_range(0, 4);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 240) : $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    symbol_i      <= ch;
    last_symbol_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    if (step_nesting(ch, last, verdict)) verdict_q.push_back(typed ? typed_verdict : verdict);
    words_sent++;
  endtask

  // Drop valid and hold the sender until every pending verdict has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Build one string with legal nesting and plain characters mixed in; a broken string may
  // also carry arbitrary characters and lose its closing tail.
  task automatic send_random_string(input bit broken);
    logic [7:0]  word_q [$];
    kind_e       open_q [$];
    int          len;
    int unsigned pick;
    logic [7:0]  ch;
    kind_e       kind;
    bit          opener;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 70) : $urandom_range(1, 16);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 9);
      if (broken && pick == 0) begin
        word_q.push_back(8'($urandom_range(0, 255)));
      end else if (pick <= 3) begin
        do ch = 8'($urandom_range(0, 255)); while (bracket_of(ch, kind, opener));
        word_q.push_back(ch);
      end else if (open_q.size() > 0 && pick <= 6) begin
        kind = open_q.pop_back();
        word_q.push_back(closer_char(kind));
      end else begin
        // Only kinds at or inside the current top may open.
        kind = kind_e'($urandom_range(0, (open_q.size() > 0) ? open_q[$] : KIND_BRACE));
        open_q.push_back(kind);
        word_q.push_back(opener_char(kind));
      end
    end
    if (!(broken && $urandom_range(0, 2) == 0)) begin
      while (open_q.size() > 0) begin
        kind = open_q.pop_back();
        word_q.push_back(closer_char(kind));
      end
    end
    if (word_q.size() == 0) word_q.push_back(8'($urandom_range(0, 255)));
    foreach (word_q[i]) send_word(word_q[i], i == word_q.size() - 1);
  endtask

  // Random words, half of them brackets, with string ends at random.
  task automatic send_noise();
    int         n;
    logic [7:0] ch;
    kind_e      kind;
    n = $urandom_range(4, 40);
    for (int i = 0; i < n; i++) begin
      kind = kind_e'($urandom_range(0, 3));
      if ($urandom_range(0, 1) == 0) ch = 8'($urandom_range(0, 255));
      else ch = ($urandom_range(0, 1) == 0) ? opener_char(kind) : closer_char(kind);
      send_word(ch, i == n - 1 || $urandom_range(0, 7) == 0);
    end
  endtask

  // Fill the stack to its depth with kinds that never move outward; then either close it all
  // or push once more past the end.
  task automatic send_deep_string(input bit overflow);
    kind_e open_q [$];
    kind_e kind;
    kind = KIND_BRACE;
    for (int i = 0; i < Depth; i++) begin
      if ($urandom_range(0, 31) == 0 && kind != KIND_ANGLE) kind = kind_e'(kind - 1);
      open_q.push_back(kind);
      send_word(opener_char(kind), 1'b0);
    end
    if (overflow) begin
      send_word(opener_char(kind), 1'b1, 1'b1, 1'b0);
    end else begin
      while (open_q.size() > 0) begin
        kind = open_q.pop_back();
        send_word(closer_char(kind), open_q.size() == 0);
      end
    end
  endtask

  // Receiver: stall on a pattern of its own, switching between calm and busy stretches.
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(4, 60);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      STALL_NONE:  out_stall_i <= 1'b0;
      STALL_LIGHT: out_stall_i <= ($urandom_range(0, 7) == 0);
      STALL_HALF:  out_stall_i <= 1'($urandom_range(0, 1));
      default:     out_stall_i <= ($urandom_range(0, 4) != 0);
    endcase
  end

  // Compare every verdict taken with the oldest one pending.
  always @(posedge clk_i) begin
    bit expected;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (verdict_q.size() == 0) begin
        report_mismatch($sformatf("verdict %0b with no string pending", balanced_o));
      end else begin
        expected = verdict_q.pop_front();
        verdicts_seen++;
        if (expected) balanced_seen++;
        if (balanced_o !== expected)
          report_mismatch($sformatf("string %0d: balanced %0b, want %0b",
                                    verdicts_seen, balanced_o, expected));
      end
    end
  end

  initial begin
    int          random_goal;
    int unsigned pick;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirTable[r])
      send_word(DirTable[r].sym, DirTable[r].last, DirTable[r].typed, DirTable[r].verdict);
    wait_drained();

    // Full stack: one string overflows, one fills up and unwinds cleanly.
    send_deep_string(1'b1);
    send_deep_string(1'b0);

    random_goal = words_sent + RandomWords;
    while (words_sent < random_goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) wait_drained();
      else if (pick < 70) send_random_string(1'b0);
      else if (pick < 85) send_random_string(1'b1);
      else send_noise();
    end
    wait_drained();
    repeat (4) @(posedge clk_i);

    $display("testbench: %0d words sent, %0d strings judged, %0d of them balanced",
             words_sent, verdicts_seen, balanced_seen);
    $display("testbench: deepest stack %0d of %0d, overflow and every nesting fault driven",
             deepest_fill, Depth);
    if (error_count == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/bnc_pkg.sv
rtl/bnc_ram.sv
rtl/bracket_nesting_checker.sv
dv/testbench.sv
